// File: src/sts_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the sample timing statistics block
package sts_pkg;
	localparam int COUNT_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [63:0] INT64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT64_MIN_U = 64'h8000_0000_0000_0000;

	typedef enum logic [1:0] {
		CLS_FIRST     = 2'd0,
		CLS_INTERVAL  = 2'd1,
		CLS_DUPLICATE = 2'd2,
		CLS_BACKWARDS = 2'd3
	} sample_class_t;
endpackage

// File: src/sample_timing_statistics_top.sv
`timescale 1ns / 1ps
// sample timing statistics: age and interval statistics with serial division
//
// one transaction in gives one transaction out. each sample runs through a
// shared bit-serial restoring divider (one quotient bit per cycle) for the
// age mean update; a forward interval adds a second divide for the interval
// mean, a shift-add multiply for the spread, and a third divide for the gap
// estimate when an expected period is set and the interval exceeds one and a
// half periods. first, duplicate and backwards samples take only the age
// divide. every result then waits on out_stall. the block takes one item at a
// time; in_stall is high from acceptance until the result transaction
// completes. the result fields are the statistics registers themselves and
// hold while out_valid is high. expected_period is to be written through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
module sample_timing_statistics_top import sts_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [63:0]         sample_time,
	input  logic [63:0]         arrival_time,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          sample_class,
	output logic signed [63:0]  min_age,
	output logic signed [63:0]  max_age,
	output logic signed [63:0]  mean_age,
	output logic [63:0]         min_interval,
	output logic [63:0]         max_interval,
	output logic [63:0]         mean_interval,
	output logic [63:0]         interval_spread,
	output logic [31:0]         interval_count,
	output logic [31:0]         duplicate_count,
	output logic [31:0]         backwards_count,
	output logic [31:0]         gap_count
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV_AGE, ST_DIV_DT, ST_MUL, ST_DIV_GAP, ST_DONE
	} state_t;

	localparam logic [63:0] AGEQ_LIM_POS = INT64_MAX_U >> FRAC_BITS;
	localparam logic [63:0] AGEQ_LIM_NEG = INT64_MIN_U >> FRAC_BITS;
	localparam logic [63:0] DTQ_LIM = {64{1'b1}} >> FRAC_BITS;

	state_t state_q;

	// statistics state
	logic [31:0]        expected_period_q;
	logic [COUNT_BITS-1:0] sample_total_q, dt_count_q, dup_total_q, back_total_q, gap_total_q;
	logic [63:0]        last_time_q;
	logic signed [63:0] age_mean_q, age_min_q, age_max_q;
	logic [63:0]        dt_mean_q, dt_m2_q, dt_min_q, dt_max_q;
	sample_class_t      class_q;

	// per-item work registers
	logic               age_up_q, dt_up_q;
	logic [63:0]        dt_q, dtq_q, d_q;
	logic [127:0]       prod_q;

	// shared serial divider
	logic [63:0]        num_q;
	logic [31:0]        den_q;
	logic [31:0]        rem_q;
	logic [5:0]         bit_cnt_q;

	logic [32:0]        rem_sh;
	logic               div_ge;
	logic [32:0]        rem_nx;
	logic [63:0]        quo_nx;

	assign rem_sh = {rem_q, num_q[63]};
	assign div_ge = rem_sh >= {1'b0, den_q};
	assign rem_nx = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	assign quo_nx = {num_q[62:0], div_ge};

	// shift-add multiplier step
	logic [64:0]        mul_sum;
	logic [127:0]       prod_nx;
	assign mul_sum = {1'b0, prod_q[127:64]} + (prod_q[0] ? {1'b0, d_q} : 65'd0);
	assign prod_nx = {mul_sum, prod_q[63:1]};

	// age of the incoming sample
	logic               arr_ge;
	logic [63:0]        age_d;
	logic signed [63:0] age_v, ageq_v;
	logic               ageq_up;
	logic [63:0]        age_diff;
	always_comb begin
		arr_ge = arrival_time >= sample_time;
		age_d = arr_ge ? (arrival_time - sample_time) : (sample_time - arrival_time);
		if (arr_ge) begin
			age_v = (age_d > INT64_MAX_U) ? INT64_MAX_U : age_d;
			ageq_v = (age_d > AGEQ_LIM_POS) ? INT64_MAX_U : (age_d << FRAC_BITS);
		end else begin
			age_v = age_d[63] ? INT64_MIN_U : (64'd0 - age_d);
			ageq_v = (age_d > AGEQ_LIM_NEG) ? INT64_MIN_U : (64'd0 - (age_d << FRAC_BITS));
		end
		ageq_up = ageq_v >= age_mean_q;
		age_diff = ageq_up ? (ageq_v - age_mean_q) : (age_mean_q - ageq_v);
	end

	// interval of the incoming sample
	logic [63:0]        dt_v, dtq_v;
	logic [COUNT_BITS-1:0] dt_count_nx;
	always_comb begin
		dt_v = sample_time - last_time_q;
		dtq_v = (dt_v > DTQ_LIM) ? '1 : (dt_v << FRAC_BITS);
		dt_count_nx = (dt_count_q == CNT_MAX) ? CNT_MAX : dt_count_q + 1'b1;
	end

	// interval mean after its divide, and the second deviation
	logic [63:0]        dt_mean_nx, e_v;
	always_comb begin
		dt_mean_nx = dt_up_q ? (dt_mean_q + quo_nx) : (dt_mean_q - quo_nx);
		e_v = dt_up_q ? (dtq_q - dt_mean_nx) : (dt_mean_nx - dtq_q);
	end

	// spread increment with saturation
	logic [63:0]        m2_inc, m2_nx;
	logic [64:0]        m2_sum;
	always_comb begin
		m2_inc = (prod_nx[127:64+FRAC_BITS] != '0) ? '1 : prod_nx[63+FRAC_BITS:FRAC_BITS];
		m2_sum = {1'b0, dt_m2_q} + {1'b0, m2_inc};
		m2_nx = m2_sum[64] ? '1 : m2_sum[63:0];
	end

	// gap threshold (p*3/2) and rounding of the period count
	logic [33:0]        gap_thr;
	logic               gap_go;
	logic [32:0]        round_sum;
	logic [64:0]        periods;
	logic [63:0]        gap_add;
	logic [COUNT_BITS-1:0] gap_nx;
	always_comb begin
		gap_thr = ({expected_period_q, 1'b0} + {1'b0, expected_period_q}) >> 1;
		gap_go = (expected_period_q != '0) && (dt_q > {30'd0, gap_thr});
		round_sum = {1'b0, rem_nx[31:0]} + {2'b0, expected_period_q[31:1]};
		periods = {1'b0, quo_nx} + {64'd0, round_sum >= {1'b0, expected_period_q}};
		gap_add = periods[63:0] - 64'd1;
		if (gap_add >= {{(64-COUNT_BITS){1'b0}}, CNT_MAX}
		    || gap_total_q > (CNT_MAX - gap_add[COUNT_BITS-1:0]))
			gap_nx = CNT_MAX;
		else
			gap_nx = gap_total_q + gap_add[COUNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			expected_period_q <= '0;
			sample_total_q <= '0;
			last_time_q <= '0;
			age_mean_q <= '0;
			age_min_q <= INT64_MAX_U;
			age_max_q <= INT64_MIN_U;
			gap_total_q <= '0;
			dt_count_q <= '0;
			dt_mean_q <= '0;
			dt_m2_q <= '0;
			dt_min_q <= '1;
			dt_max_q <= '0;
			dup_total_q <= '0;
			back_total_q <= '0;
			class_q <= CLS_FIRST;
			bit_cnt_q <= '0;
		end else begin
			if (cfg_wr_en)
				expected_period_q <= cfg_wr_data;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_total_q <= (sample_total_q == CNT_MAX) ? CNT_MAX
						                  : sample_total_q + 1'b1;
						if (age_v < age_min_q) age_min_q <= age_v;
						if (age_v > age_max_q) age_max_q <= age_v;
						age_up_q <= ageq_up;
						num_q <= age_diff;
						den_q <= (sample_total_q == CNT_MAX) ? CNT_MAX
						         : sample_total_q + 1'b1;
						rem_q <= '0;
						bit_cnt_q <= 6'd63;
						dt_q <= dt_v;
						dtq_q <= dtq_v;
						dt_up_q <= dtq_v >= dt_mean_q;
						d_q <= (dtq_v >= dt_mean_q) ? (dtq_v - dt_mean_q) : (dt_mean_q - dtq_v);
						if (sample_total_q == '0) begin
							last_time_q <= sample_time;
							class_q <= CLS_FIRST;
						end else if (sample_time == last_time_q) begin
							dup_total_q <= (dup_total_q == CNT_MAX) ? CNT_MAX
							               : dup_total_q + 1'b1;
							class_q <= CLS_DUPLICATE;
						end else if (sample_time < last_time_q) begin
							back_total_q <= (back_total_q == CNT_MAX) ? CNT_MAX
							                : back_total_q + 1'b1;
							class_q <= CLS_BACKWARDS;
						end else begin
							last_time_q <= sample_time;
							dt_count_q <= dt_count_nx;
							if (dt_v < dt_min_q) dt_min_q <= dt_v;
							if (dt_v > dt_max_q) dt_max_q <= dt_v;
							class_q <= CLS_INTERVAL;
						end
						state_q <= ST_DIV_AGE;
					end
				end
				ST_DIV_AGE: begin
					num_q <= quo_nx;
					rem_q <= rem_nx[31:0];
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						age_mean_q <= age_up_q ? (age_mean_q + quo_nx) : (age_mean_q - quo_nx);
						if (class_q == CLS_INTERVAL) begin
							num_q <= d_q;
							den_q <= dt_count_q;
							rem_q <= '0;
							bit_cnt_q <= 6'd63;
							state_q <= ST_DIV_DT;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV_DT: begin
					num_q <= quo_nx;
					rem_q <= rem_nx[31:0];
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						dt_mean_q <= dt_mean_nx;
						prod_q <= {64'd0, e_v};
						bit_cnt_q <= 6'd63;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= prod_nx;
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						dt_m2_q <= m2_nx;
						if (gap_go) begin
							num_q <= dt_q;
							den_q <= expected_period_q;
							rem_q <= '0;
							bit_cnt_q <= 6'd63;
							state_q <= ST_DIV_GAP;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DIV_GAP: begin
					num_q <= quo_nx;
					rem_q <= rem_nx[31:0];
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						if (periods > 65'd1) gap_total_q <= gap_nx;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign sample_class = class_q;
	assign min_age = age_min_q;
	assign max_age = age_max_q;
	assign mean_age = age_mean_q;
	assign min_interval = dt_min_q;
	assign max_interval = dt_max_q;
	assign mean_interval = dt_mean_q;
	assign interval_spread = dt_m2_q;
	assign interval_count = dt_count_q[31:0];
	assign duplicate_count = dup_total_q[31:0];
	assign backwards_count = back_total_q[31:0];
	assign gap_count = gap_total_q[31:0];

	// no new transaction while a result is on offer
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open while result pending");

	// an accepted sample always starts the age divide
	a_accept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DIV_AGE))
		else $error("accept did not start divide");

	// age extremes are ordered once a sample has been seen
	a_age_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid) |-> (age_min_q <= age_max_q)) else $error("age min above max");

	// interval extremes are ordered once an interval has been seen
	a_dt_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dt_count_q != '0) |-> (dt_min_q <= dt_max_q))
		else $error("interval min above max");
endmodule
